// ----- hdl/i2cm_pkg.sv -----
// shared types and constants for the i2c master byte engine
`timescale 1ns / 1ps

package i2cm_pkg;

  // reset value of the phase length register
  localparam logic [15:0] PHASE_TICKS_RESET = 16'd7;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // bits in one byte on the bus
  localparam logic [3:0] BYTE_BITS = 4'd8;

  // command codes as carried on the input stream
  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_START     = 3'd1,
    CMD_STOP      = 3'd2,
    CMD_WRITE     = 3'd3,
    CMD_READ_ACK  = 3'd4,
    CMD_READ_NACK = 3'd5
  } cmd_t;

  // one classified tick as it travels from front to back
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] wr_data;
    logic       sda_in;
  } item_t;

  // handshake pair between two stages
  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

// ----- hdl/i2c_master_byte_engine_core.sv -----
// top level of the i2c master byte engine
`timescale 1ns / 1ps

// usage
// each transfer on the slave stream is one timing tick of an open-drain i2c master.
// tdata carries the byte to write and the sampled sda level, tuser the command
// (start, stop, write byte, read with ack, read with nack; other codes do nothing).
// a command is taken only on a tick where the engine is idle, otherwise ignored.
// every tick gives exactly one result transfer on the master stream: scl and sda
// levels, busy, done, last read byte, ack seen and bus error.
// the phase length register (cfg_we / cfg_wdata) sets ticks per bus phase; write it
// only while no ticks are in flight.
// the path from tick to result runs through the front holding register, the queue and the output
// register of the engine. one tick per cycle is sustained while the result receiver does
// not stall, as the phase sequencer in the engine advances once per tick taken.
// reset returns the sequencer to idle with both lines released and the phase
// length at 7. when the result receiver stalls, the output register holds, the
// queue fills and s_axis_tready drops only once the front register is also full.

module i2c_master_byte_engine_core #(
  parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // wr_data[7:0], sda_in[8], zero fill
  input  logic [2:0]  s_axis_tuser,  // func[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // scl_level[0], sda_level[1], busy_res[2],
                                     // done_res[3], rd_data[11:4], ack_seen[12],
                                     // bus_error[13], zero fill
);
  import i2cm_pkg::*;

  logic [15:0] phase_ticks;
  hs_t         front_hs;
  hs_t         back_hs;
  item_t       front_item;
  item_t       back_item;

  // configuration
  i2cm_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .phase_ticks (phase_ticks)
  );

  // accept and classify
  i2cm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_valid   (s_axis_tvalid),
    .s_ready   (s_axis_tready),
    .s_func    (s_axis_tuser),
    .s_wr_data (s_axis_tdata[7:0]),
    .s_sda     (s_axis_tdata[8]),
    .out_valid (front_hs.valid),
    .out_ready (front_hs.ready),
    .out_item  (front_item)
  );

  // decoupling queue
  i2cm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_hs.valid),
    .in_ready  (front_hs.ready),
    .in_item   (front_item),
    .out_valid (back_hs.valid),
    .out_ready (back_hs.ready),
    .out_item  (back_item)
  );

  // bus engine
  i2cm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .phase_ticks (phase_ticks),
    .in_valid    (back_hs.valid),
    .in_ready    (back_hs.ready),
    .in_item     (back_item),
    .m_valid     (m_axis_tvalid),
    .m_ready     (m_axis_tready),
    .m_data      (m_axis_tdata)
  );

endmodule

// ----- hdl/i2cm_front.sv -----
// input stage: takes ticks from the stream and classifies the command code
`timescale 1ns / 1ps

module i2cm_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_valid,
  output logic            s_ready,
  input  logic [2:0]      s_func,
  input  logic [7:0]      s_wr_data,
  input  logic            s_sda,
  output logic            out_valid,
  input  logic            out_ready,
  output i2cm_pkg::item_t out_item
);
  import i2cm_pkg::*;

  logic  item_valid;
  item_t item;
  cmd_t  cmd_dec;

  // unused codes become no command
  always_comb begin
    unique case (s_func) inside
      CMD_START, CMD_STOP, CMD_WRITE, CMD_READ_ACK, CMD_READ_NACK: cmd_dec = cmd_t'(s_func);
      default: cmd_dec = CMD_NONE;
    endcase
  end

  assign s_ready   = !item_valid || out_ready;
  assign out_valid = item_valid;
  assign out_item  = item;

  // holding register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_ready) begin
      item_valid <= s_valid;
    end
  end

  // holding register payload
  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      item.cmd     <= cmd_dec;
      item.wr_data <= s_wr_data;
      item.sda_in  <= s_sda;
    end
  end

endmodule

// ----- hdl/i2cm_queue.sv -----
// short fifo between the classifying front and the bus engine
`timescale 1ns / 1ps

module i2cm_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  i2cm_pkg::item_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output i2cm_pkg::item_t out_item
);
  import i2cm_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           push;
  logic           pop;

  assign in_ready  = count < CW'(DEPTH);
  assign out_valid = count != '0;
  assign out_item  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue fill level beyond depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> count != '0)
    else $error("queue read while empty");

endmodule

// ----- hdl/i2cm_back.sv -----
// bus engine: advances the i2c phase sequencer one tick per item, registered result
`timescale 1ns / 1ps

module i2cm_back (
  input  logic            clk,
  input  logic            rst,
  input  logic [15:0]     phase_ticks,
  input  logic            in_valid,
  output logic            in_ready,
  input  i2cm_pkg::item_t in_item,
  output logic            m_valid,
  input  logic            m_ready,
  output logic [15:0]     m_data
);
  import i2cm_pkg::*;

  // bus phases, one-hot
  typedef enum logic [20:0] {
    PH_IDLE = 21'h000001,
    PH_ST0  = 21'h000002,
    PH_ST1  = 21'h000004,
    PH_ST2  = 21'h000008,
    PH_SP0  = 21'h000010,
    PH_SP1  = 21'h000020,
    PH_SP2  = 21'h000040,
    PH_SP3  = 21'h000080,
    PH_WB0  = 21'h000100,
    PH_WB1  = 21'h000200,
    PH_WB2  = 21'h000400,
    PH_WA0  = 21'h000800,
    PH_WA1  = 21'h001000,
    PH_WA2  = 21'h002000,
    PH_WA3  = 21'h004000,
    PH_RB0  = 21'h008000,
    PH_RB1  = 21'h010000,
    PH_RK0  = 21'h020000,
    PH_RK1  = 21'h040000,
    PH_RK2  = 21'h080000,
    PH_RK3  = 21'h100000
  } ph_t;

  // line levels set on entry to a phase, returned as {scl, sda}
  function automatic logic [1:0] enter_lines(ph_t p, logic sack, logic msb,
                                             logic scl_i, logic sda_i);
    unique case (p) inside
      PH_ST0:                  return {1'b1, 1'b1};
      PH_ST1, PH_ST2, PH_SP1:  return {scl_i, 1'b0};
      PH_SP0, PH_WB0, PH_WA0,
      PH_WA3, PH_RK0, PH_RK3:  return {1'b0, sda_i};
      PH_SP2, PH_WB2, PH_WA2,
      PH_RB1, PH_RK2:          return {1'b1, sda_i};
      PH_SP3, PH_WA1:          return {scl_i, 1'b1};
      PH_WB1:                  return {scl_i, msb};
      PH_RB0:                  return {1'b0, 1'b1};
      PH_RK1:                  return {scl_i, !sack};
      default:                 return {scl_i, sda_i};
    endcase
  endfunction

  ph_t         phase, phase_next, ph_follow;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic [15:0] tick_count, tick_count_next;
  logic        scl_reg, scl_reg_next;
  logic        sda_reg, sda_reg_next;
  logic        ack_flag, ack_flag_next;
  logic        error_flag, error_flag_next;
  logic        send_ack, send_ack_next;
  logic [7:0]  rd_hold, rd_hold_next;
  logic        done_next;
  logic        finish;
  logic        pop;

  assign in_ready = !m_valid || m_ready;
  assign pop      = in_valid && in_ready;

  // one tick of the sequencer
  always_comb begin
    phase_next      = phase;
    bit_count_next  = bit_count;
    shift_reg_next  = shift_reg;
    tick_count_next = tick_count;
    scl_reg_next    = scl_reg;
    sda_reg_next    = sda_reg;
    ack_flag_next   = ack_flag;
    error_flag_next = error_flag;
    send_ack_next   = send_ack;
    rd_hold_next    = rd_hold;
    done_next       = 1'b0;
    finish          = 1'b0;
    ph_follow       = phase;

    // command pickup while idle
    if (phase == PH_IDLE) begin
      bit_count_next = '0;
      case (in_item.cmd)
        CMD_START: phase_next = PH_ST0;
        CMD_STOP:  phase_next = PH_SP0;
        CMD_WRITE: begin
          shift_reg_next = in_item.wr_data;
          phase_next     = PH_WB0;
        end
        CMD_READ_ACK: begin
          send_ack_next  = 1'b1;
          shift_reg_next = '0;
          phase_next     = PH_RB0;
        end
        CMD_READ_NACK: begin
          send_ack_next  = 1'b0;
          shift_reg_next = '0;
          phase_next     = PH_RB0;
        end
        default: phase_next = PH_IDLE;
      endcase
      tick_count_next = '0;
      {scl_reg_next, sda_reg_next} = enter_lines(phase_next, send_ack_next,
                                                 shift_reg_next[7], scl_reg_next,
                                                 sda_reg_next);
    end

    // phase timing and end-of-phase actions
    if (phase_next != PH_IDLE) begin
      tick_count_next = tick_count_next + 16'd1;
      if (tick_count_next >= phase_ticks) begin
        ph_follow = phase_next;
        unique case (phase_next)
          PH_ST0: begin
            if (!in_item.sda_in) begin
              error_flag_next = 1'b1;
              finish          = 1'b1;
            end else begin
              ph_follow = PH_ST1;
            end
          end
          PH_ST1: begin
            if (in_item.sda_in) begin
              error_flag_next = 1'b1;
              finish          = 1'b1;
            end else begin
              ph_follow = PH_ST2;
            end
          end
          PH_ST2: begin
            scl_reg_next    = 1'b0;
            error_flag_next = 1'b0;
            finish          = 1'b1;
          end
          PH_SP0: ph_follow = PH_SP1;
          PH_SP1: ph_follow = PH_SP2;
          PH_SP2: ph_follow = PH_SP3;
          PH_WB0: ph_follow = PH_WB1;
          PH_WB1: ph_follow = PH_WB2;
          PH_WB2: begin
            shift_reg_next = {shift_reg_next[6:0], 1'b0};
            bit_count_next = bit_count_next + 4'd1;
            ph_follow      = (bit_count_next >= BYTE_BITS) ? PH_WA0 : PH_WB0;
          end
          PH_WA0: ph_follow = PH_WA1;
          PH_WA1: ph_follow = PH_WA2;
          PH_WA2: begin
            ack_flag_next = !in_item.sda_in;
            ph_follow     = PH_WA3;
          end
          PH_RB0: ph_follow = PH_RB1;
          PH_RB1: begin
            shift_reg_next = {shift_reg_next[6:0], in_item.sda_in};
            bit_count_next = bit_count_next + 4'd1;
            ph_follow      = (bit_count_next >= BYTE_BITS) ? PH_RK0 : PH_RB0;
          end
          PH_RK0: ph_follow = PH_RK1;
          PH_RK1: ph_follow = PH_RK2;
          PH_RK2: ph_follow = PH_RK3;
          PH_RK3: begin
            rd_hold_next = shift_reg_next;
            finish       = 1'b1;
          end
          default: finish = 1'b1;
        endcase
        tick_count_next = '0;
        if (finish) begin
          phase_next = PH_IDLE;
          done_next  = 1'b1;
        end else begin
          phase_next = ph_follow;
          {scl_reg_next, sda_reg_next} = enter_lines(ph_follow, send_ack_next,
                                                     shift_reg_next[7], scl_reg_next,
                                                     sda_reg_next);
        end
      end
    end
  end

  // engine state, advanced once per transfer taken
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_count  <= '0;
      shift_reg  <= '0;
      tick_count <= '0;
      scl_reg    <= 1'b1;
      sda_reg    <= 1'b1;
      ack_flag   <= 1'b0;
      error_flag <= 1'b0;
      send_ack   <= 1'b0;
      rd_hold    <= '0;
    end else if (pop) begin
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      shift_reg  <= shift_reg_next;
      tick_count <= tick_count_next;
      scl_reg    <= scl_reg_next;
      sda_reg    <= sda_reg_next;
      ack_flag   <= ack_flag_next;
      error_flag <= error_flag_next;
      send_ack   <= send_ack_next;
      rd_hold    <= rd_hold_next;
    end
  end

  // output register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (in_ready) begin
      m_valid <= in_valid;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (pop) begin
      m_data <= {2'b00, error_flag_next, ack_flag_next, rd_hold_next, done_next,
                 phase_next != PH_IDLE, sda_reg_next, scl_reg_next};
    end
  end

  a_bit_bound: assert property (@(posedge clk) disable iff (rst) bit_count <= BYTE_BITS)
    else $error("bit counter past one byte");
  a_idle_tick_clear: assert property (@(posedge clk) disable iff (rst)
      phase == PH_IDLE |-> tick_count == '0)
    else $error("tick counter not cleared while idle");
  a_pop_result: assert property (@(posedge clk) disable iff (rst) pop |=> m_valid)
    else $error("transfer taken without a result");
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
      m_valid |-> !(m_data[3] && m_data[2]))
    else $error("result marked done and busy at once");

endmodule

// ----- hdl/i2cm_top.sv -----
// phase length configuration register of the i2c master byte engine
`timescale 1ns / 1ps

module i2cm_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output logic [15:0] phase_ticks
);
  import i2cm_pkg::*;

  // phase length register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_TICKS_RESET;
    end else if (cfg_we) begin
      phase_ticks <= cfg_wdata;
    end
  end

endmodule
